FILE: sv/pttt_pkg.sv
// shared types and constants for the periodic task timer table
package pttt_pkg;

   localparam int SLOTS_DEF   = 32;
   localparam int STEP_MS_DEF = 10;
   localparam int MAX_FIRES   = 32;

   localparam logic [1:0] OP_REGISTER   = 2'd0;
   localparam logic [1:0] OP_UNREGISTER = 2'd1;
   localparam logic [1:0] OP_TICK       = 2'd2;
   localparam logic [1:0] OP_UNUSED     = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BAD_PER  = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_NOTFOUND = 2'd3;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] period_ms;
      logic [31:0] elapsed_ms;
      logic [1:0]  task_mode;
      logic [63:0] user_tag;
      logic [7:0]  slot_id;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [4:0]  result_slot;
      logic        fired;
      logic [1:0]  fired_mode;
      logic [63:0] fired_tag;
      logic        last;
   } rsp_type;

   // one slot entry as held in the table memory
   typedef struct packed {
      logic [31:0] reload;
      logic [31:0] count;
      logic [1:0]  mode;
      logic [63:0] tag;
   } entry_type;

endpackage

FILE: sv/periodic_task_timer_table_core.sv
// top level of the periodic task timer table: sequencer around the slot memory
// register: the period and then the time left are each divided by the step, then the entry is written
// rejected register goes straight to its result; unregister passes S_TICK_END; tick walks every slot
// one item at a time; the next item is taken the cycle after the last result is loaded
// reset clears live bits and the live count; the slot memory is not cleared
// fire results wait on rsp_stall, which pauses the slot walk
module periodic_task_timer_table_core #(
   parameter int SLOTS   = pttt_pkg::SLOTS_DEF,
   parameter int STEP_MS = pttt_pkg::STEP_MS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pttt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pttt_pkg::rsp_type rsp_data
);
   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam int EW = $bits(pttt_pkg::entry_type);
   localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);
   localparam logic [AW-1:0] LAST_A  = AW'(SLOTS - 1);

   typedef enum logic [2:0] {
      S_IDLE, S_DIV_RELOAD, S_DIV_COUNT, S_WRITE, S_SCAN, S_TICK_END, S_OUT
   } state_type;

   state_type          state_ff;
   pttt_pkg::req_type  req_ff;
   logic [SLOTS-1:0]   live_ff;
   logic [CW-1:0]      live_cnt_ff;
   logic [AW-1:0]      free_ff;
   logic [AW-1:0]      addr_ff;
   logic [31:0]        reload_ff;
   logic [5:0]         nfire_ff;
   pttt_pkg::rsp_type  pend_data_ff;
   logic               rsp_valid_ff;
   pttt_pkg::rsp_type  rsp_ff;

   logic               div_start;
   logic [31:0]        div_arg;
   logic               div_done;
   logic [31:0]        div_q;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   pttt_pkg::entry_type wr_entry, rd_entry;
   logic [EW-1:0]      rd_raw;
   logic [AW-1:0]      rd_addr;

   logic               out_free;
   logic [AW-1:0]      lowest_free;
   logic               sid_ok;
   logic [AW-1:0]      sid_a;
   logic               reg_go;
   logic               scan_live;
   logic               scan_due;
   logic               scan_report;
   logic               scan_block;
   logic               rsp_load;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rd_entry = pttt_pkg::entry_type'(rd_raw);

   // priority search for the lowest free slot
   always_comb begin
      lowest_free = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!live_ff[i]) begin
            lowest_free = AW'(i);
         end
      end
   end

   assign sid_a  = AW'(req_ff.slot_id);
   assign sid_ok = ({24'd0, req_ff.slot_id} < 32'(SLOTS)) && live_ff[sid_a];

   // a register item that passes both checks starts the divisions
   assign reg_go = (state_ff == S_IDLE) && req_valid
                   && (req_data.op == pttt_pkg::OP_REGISTER)
                   && (req_data.period_ms >= 32'(STEP_MS)) && (live_cnt_ff < SLOTS_C);

   // slot walk decisions for the entry in the read register
   assign scan_live   = live_ff[addr_ff];
   assign scan_due    = scan_live && (rd_entry.count <= 32'd1);
   assign scan_report = scan_due && (nfire_ff != 6'(pttt_pkg::MAX_FIRES));
   assign scan_block  = scan_report && (nfire_ff != '0) && !out_free;

   // a held fire leaves when the next fire is found; single results leave from S_OUT
   assign rsp_load = out_free && (((state_ff == S_SCAN) && scan_report && (nfire_ff != '0))
                                  || (state_ff == S_OUT));

   pttt_div #(.STEP_MS(STEP_MS)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_arg),
      .done(div_done), .quotient(div_q)
   );

   pttt_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(EW'(wr_entry)),
      .rd_addr(rd_addr), .rd_data(rd_raw)
   );

   // memory and divider control
   always_comb begin
      div_start = reg_go;
      div_arg   = reg_go ? req_data.period_ms : req_ff.period_ms;
      wr_en     = 1'b0;
      wr_addr   = addr_ff;
      wr_entry  = rd_entry;
      rd_addr   = addr_ff;
      if (state_ff == S_IDLE) begin
         rd_addr = '0;
      end
      if (state_ff == S_DIV_RELOAD && div_done) begin
         div_start = 1'b1;
         div_arg   = req_ff.period_ms - req_ff.elapsed_ms;
      end
      if (state_ff == S_WRITE) begin
         wr_en           = 1'b1;
         wr_addr         = free_ff;
         wr_entry.reload = reload_ff;
         wr_entry.count  = (req_ff.elapsed_ms >= req_ff.period_ms) ? 32'd0 : div_q;
         wr_entry.mode   = req_ff.task_mode;
         wr_entry.tag    = req_ff.user_tag;
      end
      // walk: write back the current slot and read the next, or hold while blocked
      if (state_ff == S_SCAN && !scan_block) begin
         rd_addr = addr_ff + AW'(1);
         if (scan_live) begin
            wr_en = 1'b1;
            if (scan_due) begin
               wr_entry.count = rd_entry.reload;
            end else begin
               wr_entry.count = rd_entry.count - 32'd1;
            end
         end
      end
   end

   // sequencer, output register and slot bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         live_ff      <= '0;
         live_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // output register
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
            rsp_ff       <= pend_data_ff;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  req_ff <= req_data;
                  unique case (req_data.op)
                     pttt_pkg::OP_REGISTER: begin
                        if (req_data.period_ms < 32'(STEP_MS)) begin
                           pend_data_ff <= '{status: pttt_pkg::ST_BAD_PER, last: 1'b1,
                                             default: '0};
                           state_ff <= S_OUT;
                        end else if (live_cnt_ff >= SLOTS_C) begin
                           pend_data_ff <= '{status: pttt_pkg::ST_FULL, last: 1'b1,
                                             default: '0};
                           state_ff <= S_OUT;
                        end else begin
                           free_ff  <= lowest_free;
                           state_ff <= S_DIV_RELOAD;
                        end
                     end
                     pttt_pkg::OP_UNREGISTER: begin
                        state_ff <= S_TICK_END;
                     end
                     pttt_pkg::OP_TICK: begin
                        addr_ff  <= '0;
                        nfire_ff <= '0;
                        state_ff <= S_SCAN;
                     end
                     default: begin
                        state_ff <= S_IDLE;
                     end
                  endcase
               end
            end
            S_DIV_RELOAD: begin
               if (div_done) begin
                  reload_ff <= div_q;
                  state_ff  <= S_DIV_COUNT;
               end
            end
            S_DIV_COUNT: begin
               if (div_done) begin
                  state_ff <= S_WRITE;
               end
            end
            S_WRITE: begin
               live_ff[free_ff] <= 1'b1;
               live_cnt_ff      <= live_cnt_ff + CW'(1);
               pend_data_ff     <= '{status: pttt_pkg::ST_OK, result_slot: 5'(free_ff),
                                     last: 1'b1, default: '0};
               state_ff         <= S_OUT;
            end
            S_SCAN: begin
               // hold each fire until the next one or the end settles last
               if (!scan_block) begin
                  if (scan_report) begin
                     nfire_ff     <= nfire_ff + 6'd1;
                     pend_data_ff <= '{status: pttt_pkg::ST_OK, result_slot: 5'(addr_ff),
                                       fired: 1'b1, fired_mode: rd_entry.mode,
                                       fired_tag: rd_entry.tag, last: 1'b0};
                  end
                  if (addr_ff == LAST_A) begin
                     state_ff <= S_TICK_END;
                  end else begin
                     addr_ff <= addr_ff + AW'(1);
                  end
               end
            end
            S_TICK_END: begin
               if (req_ff.op == pttt_pkg::OP_UNREGISTER) begin
                  if (sid_ok) begin
                     live_ff[sid_a] <= 1'b0;
                     live_cnt_ff    <= live_cnt_ff - CW'(1);
                     pend_data_ff   <= '{status: pttt_pkg::ST_OK, last: 1'b1, default: '0};
                  end else begin
                     pend_data_ff <= '{status: pttt_pkg::ST_NOTFOUND, last: 1'b1,
                                       default: '0};
                  end
               end else if (nfire_ff == '0) begin
                  pend_data_ff <= '{status: pttt_pkg::ST_OK, last: 1'b1, default: '0};
               end else begin
                  pend_data_ff.last <= 1'b1;
               end
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

FILE: sv/pttt_ram.sv
// generic single-port-write, one-read ram with registered read data
module pttt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: sv/pttt_div.sv
// divider by the constant tick step: registered reciprocal multiplication
module pttt_div #(
   parameter int STEP_MS = pttt_pkg::STEP_MS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   output logic        done,
   output logic [31:0] quotient
);
   // scaled reciprocal, rounded up, exact for every 32-bit dividend
   localparam int          SH       = 32 + $clog2(STEP_MS);
   localparam logic [63:0] RECIP    = ((64'd1 << SH) + 64'(STEP_MS) - 64'd1) / 64'(STEP_MS);
   localparam logic [16:0] RECIP_LO = RECIP[16:0];
   localparam logic [15:0] RECIP_HI = RECIP[32:17];

   logic [31:0] arg_ff, arg_in;
   logic [48:0] lo_ff, lo_in;
   logic [31:0] quo_ff, quo_in;
   logic        st1_ff, st2_ff;
   logic        done_ff;
   logic [47:0] hi_prod;
   logic [65:0] sum;

   // low partial product first, then the high one and the final sum
   always_comb begin
      arg_in  = start ? dividend : arg_ff;
      lo_in   = st1_ff ? 49'(arg_ff) * 49'(RECIP_LO) : lo_ff;
      hi_prod = 48'(arg_ff) * 48'(RECIP_HI);
      sum     = 66'(lo_ff) + (66'(hi_prod) << 17);
      quo_in  = st2_ff ? 32'(sum >> SH) : quo_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st1_ff  <= 1'b0;
         st2_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         st1_ff  <= start;
         st2_ff  <= st1_ff;
         done_ff <= st2_ff;
      end
      arg_ff <= arg_in;
      lo_ff  <= lo_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

FILE: sv/pttt_checker.sv
// port-level checks for the periodic task timer table, bound to the top level
module pttt_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input pttt_pkg::rsp_type rsp_data,
   input logic              rsp_valid,
   input logic              rsp_stall
);
   // a stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed under stall");

   // results outside a fire carry no tag and are marked last
   a_nofire_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.fired |-> rsp_data.fired_tag == 64'd0 && rsp_data.last)
      else $error("non-fire result not clean");

   // a fire only reports status ok
   a_fire_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.fired |-> rsp_data.status == pttt_pkg::ST_OK)
      else $error("fire with bad status");

   // the block only turns busy when it takes an item
   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      !req_valid && !req_stall |=> !req_stall)
      else $error("busy without an item");
endmodule

bind periodic_task_timer_table_core pttt_checker u_pttt_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_data(rsp_data), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall)
);

FILE: sim/periodic_task_timer_table_core_tb.sv
// testbench for the periodic task timer table: scoreboard against a behavioural table model
module periodic_task_timer_table_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSLOT   = pttt_pkg::SLOTS_DEF;
   localparam int STEP    = pttt_pkg::STEP_MS_DEF;
   localparam int LIMIT   = 2000000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   pttt_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   pttt_pkg::rsp_type rsp_data;

   periodic_task_timer_table_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #2 clock = ~clock;

   // shadow copy of the slot table
   logic        tbl_live [NSLOT];
   logic [31:0] tbl_reload [NSLOT];
   logic [31:0] tbl_count [NSLOT];
   logic [1:0]  tbl_mode [NSLOT];
   logic [63:0] tbl_tag [NSLOT];
   int          tbl_used;

   pttt_pkg::req_type pending_items[$];
   pttt_pkg::rsp_type expected_rsps[$];
   int      errors = 0;
   int      cycles = 0;
   int      gap_left = 0;
   int      stall_left = 0;
   bit      hold_off = 1'b0;
   bit      stim_done = 1'b0;

   function automatic pttt_pkg::rsp_type plain_rsp(logic [1:0] st, logic [4:0] slot);
      pttt_pkg::rsp_type r;
      r = '0;
      r.status = st;
      r.result_slot = slot;
      r.last = 1'b1;
      return r;
   endfunction

   // work out the results of one accepted item and update the shadow table
   function automatic void predict_table(pttt_pkg::req_type it);
      pttt_pkg::rsp_type r;
      int      n;
      int      lastidx;
      n = 0;
      lastidx = -1;
      case (it.op)
         pttt_pkg::OP_REGISTER: begin
            if (it.period_ms < STEP) begin
               expected_rsps.push_back(plain_rsp(pttt_pkg::ST_BAD_PER, 5'd0));
            end else if (tbl_used >= NSLOT) begin
               expected_rsps.push_back(plain_rsp(pttt_pkg::ST_FULL, 5'd0));
            end else begin
               for (int i = 0; i < NSLOT; i++) begin
                  if (!tbl_live[i]) begin
                     tbl_live[i] = 1'b1;
                     tbl_reload[i] = it.period_ms / STEP;
                     tbl_count[i] = (it.elapsed_ms >= it.period_ms) ? 32'd0 :
                                    (it.period_ms - it.elapsed_ms) / STEP;
                     tbl_mode[i] = it.task_mode;
                     tbl_tag[i] = it.user_tag;
                     tbl_used++;
                     expected_rsps.push_back(plain_rsp(pttt_pkg::ST_OK, i[4:0]));
                     break;
                  end
               end
            end
         end
         pttt_pkg::OP_UNREGISTER: begin
            if (it.slot_id < NSLOT && tbl_live[it.slot_id]) begin
               tbl_live[it.slot_id] = 1'b0;
               tbl_used--;
               expected_rsps.push_back(plain_rsp(pttt_pkg::ST_OK, 5'd0));
            end else begin
               expected_rsps.push_back(plain_rsp(pttt_pkg::ST_NOTFOUND, 5'd0));
            end
         end
         pttt_pkg::OP_TICK: begin
            for (int i = 0; i < NSLOT; i++) begin
               if (!tbl_live[i]) continue;
               if (tbl_count[i] > 1) begin
                  tbl_count[i]--;
                  continue;
               end
               tbl_count[i] = tbl_reload[i];
               if (n < pttt_pkg::MAX_FIRES) begin
                  r = '0;
                  r.status = pttt_pkg::ST_OK;
                  r.result_slot = i[4:0];
                  r.fired = 1'b1;
                  r.fired_mode = tbl_mode[i];
                  r.fired_tag = tbl_tag[i];
                  expected_rsps.push_back(r);
                  lastidx = expected_rsps.size() - 1;
                  n++;
               end
            end
            if (n == 0) expected_rsps.push_back(plain_rsp(pttt_pkg::ST_OK, 5'd0));
            else expected_rsps[lastidx].last = 1'b1;
         end
         default: ;
      endcase
   endfunction

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   // driver: one item at a time from the pending queue
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_table(req_data);
         end
         if (req_valid && req_stall) begin
            // hold the payload
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_items.size() > 0 && !hold_off) begin
            req_data <= pending_items.pop_front();
            req_valid <= 1'b1;
            if (req_valid || $urandom_range(0, 3) != 0) gap_left <= pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: compare each result with the oldest expectation
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected result %h", $realtime, rsp_data);
               errors++;
            end else begin
               if (rsp_data !== expected_rsps[0]) begin
                  $display("%0t: mismatch expected %h actual %h (st %0d/%0d slot %0d/%0d)",
                           $realtime, expected_rsps[0], rsp_data,
                           expected_rsps[0].status, rsp_data.status,
                           expected_rsps[0].result_slot, rsp_data.result_slot);
                  errors++;
               end
               void'(expected_rsps.pop_front());
            end
         end
         // random receiver stalls
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            stall_left <= pick_gap();
            rsp_stall <= 1'b0;
         end
      end
      if (cycles > LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic pttt_pkg::req_type make_item(logic [1:0] op, logic [31:0] per,
                                                   logic [31:0] ela, logic [7:0] sid);
      pttt_pkg::req_type it;
      it.op = op;
      it.period_ms = per;
      it.elapsed_ms = ela;
      it.task_mode = 2'($urandom_range(0, 3));
      it.user_tag = {$urandom(), $urandom()};
      it.slot_id = sid;
      return it;
   endfunction

   function automatic pttt_pkg::req_type random_item();
      int p;
      logic [31:0] per;
      p = $urandom_range(0, 99);
      per = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 80);
      if (p < 35) return make_item(pttt_pkg::OP_REGISTER, per,
                                   ($urandom_range(0, 5) == 0) ? $urandom()
                                                              : $urandom_range(0, 90),
                                   8'($urandom()));
      if (p < 50) return make_item(pttt_pkg::OP_UNREGISTER, $urandom(), $urandom(),
                                   ($urandom_range(0, 4) == 0) ? 8'($urandom())
                                                              : 8'($urandom_range(0, 33)));
      if (p < 97) return make_item(pttt_pkg::OP_TICK, $urandom(), $urandom(), 8'($urandom()));
      return make_item(pttt_pkg::OP_UNUSED, $urandom(), $urandom(), 8'($urandom()));
   endfunction

   initial begin
      for (int i = 0; i < NSLOT; i++) tbl_live[i] = 1'b0;
      tbl_used = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, bad period, unused op, unregister miss
      pending_items.push_back(make_item(pttt_pkg::OP_REGISTER, 32'd9, 32'd0, 8'd0));
      pending_items.push_back(make_item(pttt_pkg::OP_REGISTER, 32'd10, 32'd0, 8'd0));
      pending_items.push_back(make_item(pttt_pkg::OP_REGISTER, 32'hFFFF_FFFF, 32'hFFFF_FFF0,
                                        8'hFF));
      pending_items.push_back(make_item(pttt_pkg::OP_REGISTER, 32'd30, 32'hFFFF_FFFF, 8'd0));
      pending_items.push_back(make_item(pttt_pkg::OP_REGISTER, 32'd25, 32'd5, 8'd0));
      pending_items.push_back(make_item(pttt_pkg::OP_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                        8'hFF));
      pending_items.push_back(make_item(pttt_pkg::OP_TICK, 32'd0, 32'd0, 8'd0));
      pending_items.push_back(make_item(pttt_pkg::OP_UNUSED, 32'd50, 32'd0, 8'd0));
      pending_items.push_back(make_item(pttt_pkg::OP_UNREGISTER, 32'd0, 32'd0, 8'd1));
      pending_items.push_back(make_item(pttt_pkg::OP_UNREGISTER, 32'd0, 32'd0, 8'd1));
      pending_items.push_back(make_item(pttt_pkg::OP_UNREGISTER, 32'd0, 32'd0, 8'd32));
      pending_items.push_back(make_item(pttt_pkg::OP_UNREGISTER, 32'd0, 32'd0, 8'hFF));
      // fill the table so that it overflows, then tick everything due at once
      for (int i = 0; i < 32; i++)
         pending_items.push_back(make_item(pttt_pkg::OP_REGISTER, 32'd10, 32'd10, 8'd0));
      for (int i = 0; i < 3; i++)
         pending_items.push_back(make_item(pttt_pkg::OP_TICK, 32'd0, 32'd0, 8'd0));
      pending_items.push_back(make_item(pttt_pkg::OP_UNREGISTER, 32'd0, 32'd0, 8'd31));
      pending_items.push_back(make_item(pttt_pkg::OP_UNREGISTER, 32'd0, 32'd0, 8'd0));

      // sender holds off until every expected result is back
      wait (pending_items.size() == 0);
      hold_off = 1'b1;
      wait (!req_valid && expected_rsps.size() == 0);
      repeat (80) @(posedge clock);
      hold_off = 1'b0;

      // random part: free most slots first so registrations succeed again
      for (int i = 0; i < 28; i++)
         pending_items.push_back(make_item(pttt_pkg::OP_UNREGISTER, 32'd0, 32'd0, i[7:0]));
      for (int i = 0; i < 240; i++) pending_items.push_back(random_item());

      wait (pending_items.size() == 0);
      wait (!req_valid && expected_rsps.size() == 0);
      repeat (200) @(posedge clock);
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

FILE: periodic_task_timer_table_core.f
sv/pttt_pkg.sv
sv/pttt_ram.sv
sv/pttt_div.sv
sv/periodic_task_timer_table_core.sv
sv/pttt_checker.sv
sim/periodic_task_timer_table_core_tb.sv
